/* src/bda_pkg.sv */
`timescale 1ns / 1ps

package bda_pkg;

    // Field widths
    localparam int PRESS_W    = 5;
    localparam int PERIOD_W   = 8;
    localparam int TIME_W     = 16;
    localparam int REP_EN_W   = 5;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TIME = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_TIME     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_TIME   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_ENABLE = 3'd4;

    // Reset values of the registers
    localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD = 8'd5;
    localparam logic [TIME_W-1:0]   RST_DEBOUNCE_TIME = 16'd30;
    localparam logic [TIME_W-1:0]   RST_HOLD_TIME     = 16'd600;
    localparam logic [TIME_W-1:0]   RST_REPEAT_TIME   = 16'd150;
    localparam logic [REP_EN_W-1:0] RST_REPEAT_ENABLE = 5'd0;

    typedef struct packed {
        logic [PERIOD_W-1:0] sample_period;
        logic [TIME_W-1:0]   debounce_time;
        logic [TIME_W-1:0]   hold_time;
        logic [TIME_W-1:0]   repeat_time;
        logic [REP_EN_W-1:0] repeat_enable;
    } t_cfg;

endpackage

/* src/button_debounce_autorepeat_top.sv */
// The clicks of a tick beat appear on the output in the cycle after the beat is taken.
// One beat per cycle if not stalled; the output register frees in the cycle it is taken.
// Reset (synchronous, active low): registers return to 5 / 30 / 600 / 150 / 0, the
// sample divider and all button timers and flags clear, the output register empties.
`timescale 1ns / 1ps

module button_debounce_autorepeat_top #(
    parameter int NUM_BUTTONS = 5,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Tick channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bda_pkg::PRESS_W-1:0]      i_pressed,
    // Click channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bda_pkg::PRESS_W-1:0]      o_clicks,
    // Register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bda_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bda_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bda_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import bda_pkg::*;

    localparam logic [PERIOD_W-1:0] DIV_MAX = {PERIOD_W{1'b1}};

    t_cfg                  r_cfg;
    logic [PERIOD_W-1:0]   r_div;
    logic [PERIOD_W-1:0]   n_div;
    logic                  r_out_valid;
    logic [PRESS_W-1:0]    r_clicks;

    logic                  w_accept;
    logic                  w_cfg_wr;
    logic [REG_IDX_W-1:0]  w_idx;
    logic [PERIOD_W-1:0]   w_div_inc;
    logic                  w_eval;
    logic                  w_step;
    logic [NUM_BUTTONS-1:0] w_click;
    logic [PRESS_W-1:0]    n_clicks;

    // ------------------------------------------------------------------
    // Register port: writes land on the access phase, reads are decoded
    // straight from the register bank.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_idx    = paddr[APB_ADDR_W-1:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_period <= RST_SAMPLE_PERIOD;
            r_cfg.debounce_time <= RST_DEBOUNCE_TIME;
            r_cfg.hold_time     <= RST_HOLD_TIME;
            r_cfg.repeat_time   <= RST_REPEAT_TIME;
            r_cfg.repeat_enable <= RST_REPEAT_ENABLE;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_SAMPLE_PERIOD: r_cfg.sample_period <= pwdata[PERIOD_W-1:0];
                REG_DEBOUNCE_TIME: r_cfg.debounce_time <= pwdata[TIME_W-1:0];
                REG_HOLD_TIME:     r_cfg.hold_time     <= pwdata[TIME_W-1:0];
                REG_REPEAT_TIME:   r_cfg.repeat_time   <= pwdata[TIME_W-1:0];
                REG_REPEAT_ENABLE: r_cfg.repeat_enable <= pwdata[REP_EN_W-1:0];
                default: begin
                    // unmapped: drop the write
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SAMPLE_PERIOD: prdata = APB_DATA_W'(r_cfg.sample_period);
            REG_DEBOUNCE_TIME: prdata = APB_DATA_W'(r_cfg.debounce_time);
            REG_HOLD_TIME:     prdata = APB_DATA_W'(r_cfg.hold_time);
            REG_REPEAT_TIME:   prdata = APB_DATA_W'(r_cfg.repeat_time);
            REG_REPEAT_ENABLE: prdata = APB_DATA_W'(r_cfg.repeat_enable);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: take a new beat whenever the output register is empty or
    // is being drained in this same cycle.
    // ------------------------------------------------------------------
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Sample divider: advance on every tick (saturating), evaluate once it
    // reaches the sample period, then restart from zero. The count at the
    // evaluation is the elapsed time handed to the button timers.
    // ------------------------------------------------------------------
    assign w_div_inc = (r_div != DIV_MAX) ? r_div + 1'b1 : DIV_MAX;
    assign w_eval    = (w_div_inc >= r_cfg.sample_period);
    assign w_step    = w_accept && w_eval;

    always_comb begin
        n_div = r_div;
        if (w_accept) begin
            n_div = w_eval ? '0 : w_div_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= '0;
        end else begin
            r_div <= n_div;
        end
    end

    // ------------------------------------------------------------------
    // One timer channel per button. Buttons with no input bit always read
    // as released and never click.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < NUM_BUTTONS; gi++) begin : g_btn
        logic w_down;
        logic w_rep;

        if (gi < PRESS_W) begin : g_wired
            assign w_down = i_pressed[gi];
            assign w_rep  = r_cfg.repeat_enable[gi];
        end else begin : g_unwired
            assign w_down = 1'b0;
            assign w_rep  = 1'b0;
        end

        bda_button #(
            .TIMER_WIDTH (TIMER_WIDTH)
        ) u_button (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_step    (w_step),
            .i_down    (w_down),
            .i_rep     (w_rep),
            .i_elapsed (w_div_inc),
            .i_cfg     (r_cfg),
            .o_click   (w_click[gi])
        );
    end

    // Map the per-button clicks onto the fixed-width output field
    for (genvar gj = 0; gj < PRESS_W; gj++) begin : g_out
        if (gj < NUM_BUTTONS) begin : g_used
            assign n_clicks[gj] = w_click[gj];
        end else begin : g_unused
            assign n_clicks[gj] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on every accepted tick beat (non-evaluation
    // ticks carry an all-zero mask), hold while the sink stalls.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_clicks <= n_clicks;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_clicks    = r_clicks;

    // Reset empties the output register
    a_reset_empties_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result blocks new ticks
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("tick taken while result stalled");

    // A tick without an evaluation never produces clicks
    a_no_eval_no_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_eval) |=> (o_clicks == '0))
        else $error("click on a non-evaluation tick");

    // The divider is zero right after every evaluation
    a_div_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> (r_div == '0))
        else $error("sample divider not restarted");

endmodule

/* src/bda_button.sv */
`timescale 1ns / 1ps

module bda_button #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_down,
    input  logic                       i_rep,
    input  logic [bda_pkg::PERIOD_W-1:0] i_elapsed,
    input  bda_pkg::t_cfg              i_cfg,
    output logic                       o_click
);
    import bda_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > TIME_W) ? TIMER_WIDTH : TIME_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    logic                   r_active;
    logic                   r_given;
    logic [TIMER_WIDTH-1:0] r_held;
    logic [TIMER_WIDTH-1:0] r_tsr;

    logic                   n_active;
    logic                   n_given;
    logic [TIMER_WIDTH-1:0] n_held;
    logic [TIMER_WIDTH-1:0] n_tsr;

    logic [TIMER_WIDTH:0]   w_held_sum;
    logic [TIMER_WIDTH:0]   w_tsr_sum;
    logic [TIMER_WIDTH-1:0] w_held;
    logic [TIMER_WIDTH-1:0] w_tsr;
    logic                   w_given;
    logic                   w_first;
    logic                   w_repeat;

    // Saturating advance by the elapsed tick count
    assign w_held_sum = {1'b0, r_held} + (TIMER_WIDTH+1)'(i_elapsed);
    assign w_tsr_sum  = {1'b0, r_tsr}  + (TIMER_WIDTH+1)'(i_elapsed);

    always_comb begin
        if (r_active) begin
            w_held  = w_held_sum[TIMER_WIDTH] ? TIMER_MAX : w_held_sum[TIMER_WIDTH-1:0];
            w_tsr   = w_tsr_sum[TIMER_WIDTH]  ? TIMER_MAX : w_tsr_sum[TIMER_WIDTH-1:0];
            w_given = r_given;
        end else begin
            w_held  = '0;
            w_tsr   = '0;
            w_given = 1'b0;
        end
    end

    assign w_first  = !w_given && (CMP_W'(w_held) >= CMP_W'(i_cfg.debounce_time));
    assign w_repeat = w_given && i_rep
                   && (CMP_W'(w_held) >= CMP_W'(i_cfg.hold_time))
                   && (CMP_W'(w_tsr)  >= CMP_W'(i_cfg.repeat_time));

    assign o_click = i_step && i_down && (w_first || w_repeat);

    always_comb begin
        n_active = r_active;
        n_given  = r_given;
        n_held   = r_held;
        n_tsr    = r_tsr;
        if (i_step) begin
            if (!i_down) begin
                n_active = 1'b0;
                n_given  = 1'b0;
                n_held   = '0;
                n_tsr    = '0;
            end else begin
                n_active = 1'b1;
                n_given  = w_given || w_first;
                n_held   = w_held;
                n_tsr    = (w_first || w_repeat) ? '0 : w_tsr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_given  <= 1'b0;
            r_held   <= '0;
            r_tsr    <= '0;
        end else begin
            r_active <= n_active;
            r_given  <= n_given;
            r_held   <= n_held;
            r_tsr    <= n_tsr;
        end
    end

    // A click always leaves the press marked as clicked
    a_click_sets_given: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_click |=> r_given)
        else $error("click without click_given");

    // Clicked implies the press is being tracked
    a_given_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_given |-> r_active)
        else $error("click_given on an inactive button");

    // Idle buttons keep their timers at zero
    a_idle_timers_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_held == '0 && r_tsr == '0))
        else $error("timers running on an inactive button");

endmodule
